FILE: rtl/tlpt_pkg.sv
// Shared types and constants for the two-level page table engine.
package tlpt_pkg;

   localparam int NUM_PROCS_DEF  = 16;
   localparam int NUM_TABLES_DEF = 1024;
   localparam int NUM_FRAMES_DEF = 4096;

   localparam int VA_W       = 27;
   localparam int OFFSET_W   = 15;
   localparam int SLOT_W     = 6;
   localparam int PID_W      = 8;
   localparam int FRAME_W    = 12;
   localparam int TABLE_W    = 10;
   localparam int ENTRIES    = 64;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_NO_FRAME = 2'd2,
      ST_NO_TABLE = 2'd3
   } status_type;

   typedef enum logic {
      OP_TRANSLATE = 1'b0,
      OP_MAP       = 1'b1
   } opcode_type;

   typedef struct packed {
      logic              opcode;
      logic [PID_W-1:0]  proc_num;
      logic [VA_W-1:0]   vaddr;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [VA_W-1:0]   paddr;
      logic              newly_mapped;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [TABLE_W-1:0] table_num;
   } l1_entry_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } l2_entry_type;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_IDX   = 9'b000000100,
      S_L1    = 9'b000001000,
      S_L2    = 9'b000010000,
      S_CHK   = 9'b000100000,
      S_ZERO  = 9'b001000000,
      S_INST  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

endpackage

FILE: rtl/tlpt_ram.sv
// Single-port synchronous RAM with registered read data.
module tlpt_ram import tlpt_pkg::*; #(
   parameter int WIDTH = FRAME_W + 1,
   parameter int DEPTH = NUM_TABLES_DEF * ENTRIES,
   parameter int AW    = $clog2(NUM_TABLES_DEF * ENTRIES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/two_level_page_table_engine_unit.sv
// Two-level page table engine: translate and map with lowest-free allocation.
//
// Frames and second-level tables are never released, so the lowest free one is
// always the next value of a count; no bitmap scan is needed. After reset the
// first-level memory is cleared one entry a cycle, all NUM_PROCS*64 entries,
// before the first request is taken. A translate, or a map of a page that is
// already mapped, steps through index, first-level read, second-level read,
// check and done states, paced by two dependent memory reads; the next request
// is taken only once the engine is back in idle. A map that installs a frame in
// an existing table also passes through an install state; one that also
// allocates a new second-level table first marks its 64 entries invalid
// through the single write port. The result sits in an output register, so the
// next request can enter while it waits; if that request finishes first, the
// engine holds it and stalls the input until the output register frees up.
module two_level_page_table_engine_unit import tlpt_pkg::*; #(
   parameter int NUM_PROCS  = NUM_PROCS_DEF,
   parameter int NUM_TABLES = NUM_TABLES_DEF,
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int L1_DEPTH = NUM_PROCS * ENTRIES;
   localparam int L1_AW    = $clog2(L1_DEPTH);
   localparam int TW       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int L2_DEPTH = NUM_TABLES * ENTRIES;
   localparam int L2_AW    = TW + SLOT_W;
   localparam int FCW      = $clog2(NUM_FRAMES + 1);
   localparam int TCW      = $clog2(NUM_TABLES + 1);

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [L1_AW-1:0]      clr_ff, clr_in;
   logic [L1_AW-1:0]      l1_addr_ff, l1_addr_in;
   logic [SLOT_W-1:0]     sweep_ff, sweep_in;
   logic [TW-1:0]         tab_ff, tab_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic [FCW-1:0]        fcnt_ff, fcnt_in;
   logic [TCW-1:0]        tcnt_ff, tcnt_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  l1_we;
   logic [L1_AW-1:0]      l1_addr;
   l1_entry_type          l1_wdata, l1_q;
   logic                  l2_we;
   logic [L2_AW-1:0]      l2_addr;
   l2_entry_type          l2_wdata, l2_q;

   logic [PID_W-1:0]      pid_mod;
   logic [SLOT_W-1:0]     slot;
   logic [OFFSET_W-1:0]   offset;
   logic                  out_free;

   assign slot     = req_ff.vaddr[OFFSET_W +: SLOT_W];
   assign offset   = req_ff.vaddr[OFFSET_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pid_mod = req_ff.proc_num;
      for (int k = PID_W - 1; k >= 0; k--) begin
         if (32'(pid_mod) >= 32'(NUM_PROCS << k)) begin
            pid_mod = PID_W'(32'(pid_mod) - 32'(NUM_PROCS << k));
         end
      end
   end

   tlpt_ram #(.WIDTH(TABLE_W + 1), .DEPTH(L1_DEPTH), .AW(L1_AW)) u_l1 (
      .clock   (clock),
      .wr_en   (l1_we),
      .addr    (l1_addr),
      .wr_data (l1_wdata),
      .rd_data (l1_q)
   );

   tlpt_ram #(.WIDTH(FRAME_W + 1), .DEPTH(L2_DEPTH), .AW(L2_AW)) u_l2 (
      .clock   (clock),
      .wr_en   (l2_we),
      .addr    (l2_addr),
      .wr_data (l2_wdata),
      .rd_data (l2_q)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      clr_in       = clr_ff;
      l1_addr_in   = l1_addr_ff;
      sweep_in     = sweep_ff;
      tab_in       = tab_ff;
      frame_in     = frame_ff;
      fcnt_in      = fcnt_ff;
      tcnt_in      = tcnt_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      l1_we        = 1'b0;
      l1_addr      = l1_addr_ff;
      l1_wdata     = '0;
      l2_we        = 1'b0;
      l2_addr      = {tab_ff, slot};
      l2_wdata     = '0;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            l1_we   = 1'b1;
            l1_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == L1_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            l1_addr_in = L1_AW'({pid_mod,
                                 req_ff.vaddr[OFFSET_W + SLOT_W +: SLOT_W]});
            state_in   = S_L1;
         end
         S_L1: begin
            state_in = S_L2;
         end
         S_L2: begin
            tab_in   = TW'(l1_q.table_num);
            l2_addr  = {TW'(l1_q.table_num), slot};
            state_in = S_CHK;
         end
         S_CHK: begin
            res_in = '0;
            if (l1_q.valid && l2_q.valid) begin
               res_in.status = ST_OK;
               res_in.paddr  = {l2_q.frame, offset};
               state_in      = S_DONE;
            end else if (req_ff.opcode != OP_MAP) begin
               res_in.status = ST_UNMAPPED;
               state_in      = S_DONE;
            end else if (32'(fcnt_ff) >= NUM_FRAMES) begin
               res_in.status = ST_NO_FRAME;
               state_in      = S_DONE;
            end else begin
               frame_in = FRAME_W'(fcnt_ff);
               fcnt_in  = fcnt_ff + 1'b1;
               if (l1_q.valid) begin
                  state_in = S_INST;
               end else if (32'(tcnt_ff) >= NUM_TABLES) begin
                  res_in.status = ST_NO_TABLE;
                  state_in      = S_DONE;
               end else begin
                  tab_in             = TW'(tcnt_ff);
                  tcnt_in            = tcnt_ff + 1'b1;
                  l1_we              = 1'b1;
                  l1_wdata.valid     = 1'b1;
                  l1_wdata.table_num = TABLE_W'(tcnt_ff);
                  sweep_in           = '0;
                  state_in           = S_ZERO;
               end
            end
         end
         S_ZERO: begin
            l2_we    = 1'b1;
            l2_addr  = {tab_ff, sweep_ff};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SLOT_W'(ENTRIES - 1)) begin
               state_in = S_INST;
            end
         end
         S_INST: begin
            l2_we               = 1'b1;
            l2_wdata.valid      = 1'b1;
            l2_wdata.frame      = frame_ff;
            res_in.status       = ST_OK;
            res_in.paddr        = {frame_ff, offset};
            res_in.newly_mapped = 1'b1;
            state_in            = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fcnt_ff      <= '0;
         tcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fcnt_ff      <= fcnt_in;
         tcnt_ff      <= tcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      l1_addr_ff  <= l1_addr_in;
      sweep_ff    <= sweep_in;
      tab_ff      <= tab_in;
      frame_ff    <= frame_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
